>>> design/fcw_pkg.sv
package fcw_pkg;

  // Table and field geometry.
  localparam int unsigned FAT_BYTES_DEF = 8192;
  localparam int unsigned FAT_ADDR_W    = 13;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;

  // FAT12 entry constants.
  localparam logic [11:0] ENTRY_MASK = 12'hFFF;
  localparam logic [11:0] CHAIN_END  = 12'hFF8;
  localparam logic [7:0]  SPC_MAX    = 8'd128;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_LBA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_SECS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LBA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPC       = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_OPEN    = 2'd1,
    OP_ROOT    = 2'd2,
    OP_ADVANCE = 2'd3
  } fcw_op_e;

  // Volume geometry held by the configuration registers.
  typedef struct packed {
    logic [13:0] fat_size;
    logic [15:0] root_lba;
    logic [12:0] root_secs;
    logic [15:0] data_lba;
    logic [7:0]  spc;
  } fcw_cfg_t;

  // One access to the FAT byte memory.
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [FAT_ADDR_W-1:0] addr;
    logic [7:0]            wdata;
  } fcw_mem_req_t;

endpackage

>>> design/fat12_cluster_chain_walker_top.sv
// FAT12 cluster chain walker. Raise start_i with an opcode while busy_o is low:
// load a FAT byte, open a file at its first cluster, open the root directory,
// or advance one sector. Every item yields exactly one result, strobed on done_o
// for a single cycle, that the receiver must take then. The next item can be
// accepted in the strobe cycle. An advance that crosses into the next cluster
// goes through the read states S_RD0 and S_RD1 before the result step, since
// both bytes of the packed FAT entry are fetched in turn through the one port
// of the FAT memory. Write the configuration registers only while the
// block is idle. FAT bytes must be loaded before the chain reaches them.
module fat12_cluster_chain_walker_top
  import fcw_pkg::*;
#(
  parameter int unsigned FatBytes = FAT_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            opcode_i,
  input  logic [12:0]           fat_address_i,
  input  logic [7:0]            fat_byte_i,
  input  logic [11:0]           first_cluster_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic [19:0]           sector_lba_o,
  output logic                  end_of_data_o,
  output logic                  bad_cluster_o,
  output logic [11:0]           cluster_now_o
);

  fcw_cfg_t     cfg_q;
  fcw_mem_req_t mem_req;
  logic [7:0]   mem_rdata;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q          <= '0;
      cfg_q.spc      <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FAT_SIZE:  cfg_q.fat_size  <= cfg_data_i[13:0];
        CFG_ROOT_LBA:  cfg_q.root_lba  <= cfg_data_i;
        CFG_ROOT_SECS: cfg_q.root_secs <= cfg_data_i[12:0];
        CFG_DATA_LBA:  cfg_q.data_lba  <= cfg_data_i;
        CFG_SPC:       cfg_q.spc       <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  fcw_fat_mem #(
    .Depth(FatBytes)
  ) u_fat_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  fcw_walker #(
    .FatBytes(FatBytes)
  ) u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .opcode_i       (opcode_i),
    .fat_address_i  (fat_address_i),
    .fat_byte_i     (fat_byte_i),
    .first_cluster_i(first_cluster_i),
    .cfg_i          (cfg_q),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .sector_lba_o   (sector_lba_o),
    .end_of_data_o  (end_of_data_o),
    .bad_cluster_o  (bad_cluster_o),
    .cluster_now_o  (cluster_now_o)
  );

endmodule

>>> design/fcw_fat_mem.sv
module fcw_fat_mem
  import fcw_pkg::*;
#(
  parameter int unsigned Depth = FAT_BYTES_DEF
) (
  input  logic         clk_i,
  input  fcw_mem_req_t req_i,
  output logic [7:0]   rdata_o
);

  localparam int unsigned AW = $clog2(Depth);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // Single port: the walker never writes and reads in the same cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/fcw_walker.sv
module fcw_walker
  import fcw_pkg::*;
#(
  parameter int unsigned FatBytes = FAT_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [1:0]   opcode_i,
  input  logic [12:0]  fat_address_i,
  input  logic [7:0]   fat_byte_i,
  input  logic [11:0]  first_cluster_i,
  input  fcw_cfg_t     cfg_i,
  output fcw_mem_req_t mem_req_o,
  input  logic [7:0]   mem_rdata_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [19:0]  sector_lba_o,
  output logic         end_of_data_o,
  output logic         bad_cluster_o,
  output logic [11:0]  cluster_now_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_CALC
  } state_e;

  state_e      state_q;
  logic [11:0] cur_q;
  logic [6:0]  sic_q;
  logic [12:0] root_idx_q;
  logic        root_q;
  logic        fin_q;
  logic        bad_q;
  logic [12:0] idx_q;
  logic [7:0]  byte0_q;
  logic        done_q;
  logic [19:0] lba_q;
  logic        eod_q;
  logic        badout_q;
  logic [11:0] clout_q;

  fcw_op_e     op;
  logic        accept;
  logic [7:0]  spc_eff;
  logic [13:0] limit;
  logic [12:0] idx;
  logic        idx_end;
  logic        sic_wrap;
  logic        root_more;
  logic        load_ok;
  logic        need_fat;
  logic [15:0] pair;
  logic [11:0] entry;
  logic [11:0] off;
  logic [19:0] prod;
  logic [19:0] lba;

  assign op     = fcw_op_e'(opcode_i);
  assign accept = start_i && (state_q == S_IDLE);

  // Cluster size clamped to 1..128.
  always_comb begin
    priority if (cfg_i.spc == 8'd0) begin
      spc_eff = 8'd1;
    end else if (cfg_i.spc > SPC_MAX) begin
      spc_eff = SPC_MAX;
    end else begin
      spc_eff = cfg_i.spc;
    end
  end

  // Valid FAT bytes never exceed the table depth.
  assign limit = (cfg_i.fat_size > 14'(FatBytes)) ? 14'(FatBytes) : cfg_i.fat_size;

  // Byte offset of the packed entry: cluster * 3 / 2.
  assign idx       = {1'b0, cur_q} + {2'b00, cur_q[11:1]};
  assign idx_end   = ({1'b0, idx} + 14'd1) >= limit;
  assign sic_wrap  = ({1'b0, sic_q} + 8'd1) >= spc_eff;
  assign root_more = ({1'b0, root_idx_q} + 14'd1) < {1'b0, cfg_i.root_secs};
  assign load_ok   = {1'b0, fat_address_i} < 14'(FatBytes);
  assign need_fat  = !fin_q && !root_q && sic_wrap && (cur_q >= 12'd2) && !idx_end;

  // Entry decode once both bytes are in.
  assign pair  = {mem_rdata_i, byte0_q};
  assign entry = cur_q[0] ? pair[15:4] : (pair[11:0] & ENTRY_MASK);

  // Sector address of the cursor.
  assign off  = cur_q - 12'd2;
  assign prod = {8'd0, off} * {12'd0, spc_eff};
  always_comb begin
    priority if (fin_q) begin
      lba = '0;
    end else if (root_q) begin
      lba = {4'd0, cfg_i.root_lba} + {7'd0, root_idx_q};
    end else if (cur_q >= 12'd2) begin
      lba = {4'd0, cfg_i.data_lba} + prod + {13'd0, sic_q};
    end else begin
      lba = '0;
    end
  end

  // Memory: an in-range load writes, a cluster change reads two bytes.
  always_comb begin
    mem_req_o = '0;
    if (accept && (op == OP_LOAD)) begin
      mem_req_o.we    = load_ok;
      mem_req_o.addr  = fat_address_i;
      mem_req_o.wdata = fat_byte_i;
    end else if (accept && (op == OP_ADVANCE) && need_fat) begin
      mem_req_o.re   = 1'b1;
      mem_req_o.addr = idx;
    end else if (state_q == S_RD0) begin
      mem_req_o.re   = 1'b1;
      mem_req_o.addr = idx_q + 13'd1;
    end
  end

  // Sequencer, cursor state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cur_q      <= '0;
      sic_q      <= '0;
      root_idx_q <= '0;
      root_q     <= 1'b0;
      fin_q      <= 1'b1;
      bad_q      <= 1'b0;
      idx_q      <= '0;
      byte0_q    <= '0;
      done_q     <= 1'b0;
      lba_q      <= '0;
      eod_q      <= 1'b0;
      badout_q   <= 1'b0;
      clout_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            bad_q   <= 1'b0;
            state_q <= S_CALC;
            unique case (op)
              OP_LOAD: begin
              end
              OP_OPEN: begin
                root_q <= 1'b0;
                cur_q  <= first_cluster_i;
                sic_q  <= '0;
                fin_q  <= (first_cluster_i < 12'd2) || (first_cluster_i >= CHAIN_END);
                bad_q  <= first_cluster_i < 12'd2;
              end
              OP_ROOT: begin
                root_q     <= 1'b1;
                root_idx_q <= '0;
                fin_q      <= cfg_i.root_secs == 13'd0;
              end
              OP_ADVANCE: begin
                if (!fin_q) begin
                  if (root_q) begin
                    if (root_more) begin
                      root_idx_q <= root_idx_q + 13'd1;
                    end else begin
                      fin_q <= 1'b1;
                    end
                  end else if (!sic_wrap) begin
                    sic_q <= sic_q + 7'd1;
                  end else begin
                    sic_q <= '0;
                    if (need_fat) begin
                      idx_q   <= idx;
                      state_q <= S_RD0;
                    end else begin
                      fin_q <= 1'b1;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD0: begin
          byte0_q <= mem_rdata_i;
          state_q <= S_RD1;
        end
        S_RD1: begin
          if (entry >= CHAIN_END) begin
            fin_q <= 1'b1;
          end else begin
            cur_q <= entry;
            if (entry < 12'd2) begin
              fin_q <= 1'b1;
              bad_q <= 1'b1;
            end
          end
          state_q <= S_CALC;
        end
        S_CALC: begin
          done_q   <= 1'b1;
          lba_q    <= lba;
          eod_q    <= fin_q;
          badout_q <= bad_q;
          clout_q  <= root_q ? 12'd0 : cur_q;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = state_q != S_IDLE;
  assign done_o        = done_q;
  assign sector_lba_o  = lba_q;
  assign end_of_data_o = eod_q;
  assign bad_cluster_o = badout_q;
  assign cluster_now_o = clout_q;

  // A result is strobed for one cycle only.
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  // A finished chain reports no sector.
  a_end_no_lba : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && eod_q) |-> (lba_q == 20'd0))
    else $error("sector reported after end of data");

  // The second FAT byte read always follows the first.
  a_rd_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD1) |-> ($past(state_q) == S_RD0))
    else $error("FAT read sequence broken");

  // Every result comes from the calculation step.
  a_done_from_calc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> ($past(state_q) == S_CALC))
    else $error("result strobed outside the calculation step");

endmodule

>>> verif/fat12_cluster_chain_walker_top_tb.sv
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_top_tb;
  import fcw_pkg::*;

  localparam int unsigned STALL_LIMIT = 400;

  // Expected contents of one result item.
  typedef struct packed {
    logic [19:0] lba;
    logic        eod;
    logic        bad;
    logic [11:0] cl;
  } sector_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic [1:0]            opcode_i = OP_LOAD;
  logic [12:0]           fat_address_i = '0;
  logic [7:0]            fat_byte_i = '0;
  logic [11:0]           first_cluster_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_FAT_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [19:0]           sector_lba_o;
  logic                  end_of_data_o;
  logic                  bad_cluster_o;
  logic [11:0]           cluster_now_o;

  // Mirror of the walker: FAT bytes, cursor and volume geometry.
  logic [7:0]     fat_mem [FAT_BYTES_DEF];
  bit             fat_known [FAT_BYTES_DEF];
  logic [11:0]    cur_cluster = '0;
  logic [6:0]     sec_in_cluster = '0;
  logic [12:0]    root_index = '0;
  logic           root_mode = 1'b0;
  logic           chain_done = 1'b1;
  fcw_cfg_t       geo = '{fat_size: '0, root_lba: '0, root_secs: '0, data_lba: '0,
                          spc: 8'd1};

  sector_report_t expected_reports [$];
  sector_report_t oldest_report;
  int             mismatches = 0;
  int             items_sent = 0;
  int             reports_checked = 0;
  int             chains_walked = 0;
  int             gap_pct = 0;
  int             idle_cycles = 0;

  fat12_cluster_chain_walker_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .fat_address_i  (fat_address_i),
    .fat_byte_i     (fat_byte_i),
    .first_cluster_i(first_cluster_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .sector_lba_o   (sector_lba_o),
    .end_of_data_o  (end_of_data_o),
    .bad_cluster_o  (bad_cluster_o),
    .cluster_now_o  (cluster_now_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Cluster size as the walker uses it: zero counts as one, the top is 128.
  function automatic int unsigned spc_eff();
    if (geo.spc == 0) return 1;
    if (geo.spc > SPC_MAX) return int'(SPC_MAX);
    return int'(geo.spc);
  endfunction

  function automatic int unsigned fat_limit();
    if (geo.fat_size > FAT_BYTES_DEF) return FAT_BYTES_DEF;
    return int'(geo.fat_size);
  endfunction

  // Packed 12-bit FAT entry of a cluster; out of range reads as end of chain.
  function automatic logic [11:0] fat_entry(logic [11:0] cl);
    int unsigned idx;
    logic [15:0] pair;
    if (cl < 2) return ENTRY_MASK;
    idx = (int'(cl) * 3) / 2;
    if (idx + 1 >= fat_limit()) return ENTRY_MASK;
    pair = {fat_mem[idx + 1], fat_mem[idx]};
    return cl[0] ? pair[15:4] : pair[11:0];
  endfunction

  // Applies one item to the mirror and returns the result it should produce.
  function automatic sector_report_t step_walker(fcw_op_e op, logic [12:0] addr,
                                                 logic [7:0] data, logic [11:0] first);
    sector_report_t rep;
    logic [11:0] nxt;
    logic [31:0] lba;
    rep = '0;
    case (op)
      OP_LOAD: begin
        fat_mem[addr] = data;
        fat_known[addr] = 1'b1;
      end
      OP_OPEN: begin
        root_mode = 1'b0;
        cur_cluster = first;
        sec_in_cluster = '0;
        chain_done = 1'b0;
        if (first < 2) begin
          chain_done = 1'b1;
          rep.bad = 1'b1;
        end else if (first >= CHAIN_END) begin
          chain_done = 1'b1;
        end
      end
      OP_ROOT: begin
        root_mode = 1'b1;
        root_index = '0;
        chain_done = (geo.root_secs == 0);
      end
      default: begin
        if (!chain_done) begin
          if (root_mode) begin
            if (int'(root_index) + 1 < int'(geo.root_secs)) root_index = root_index + 1'b1;
            else chain_done = 1'b1;
          end else if (int'(sec_in_cluster) + 1 < spc_eff()) begin
            sec_in_cluster = sec_in_cluster + 1'b1;
          end else begin
            sec_in_cluster = '0;
            nxt = fat_entry(cur_cluster);
            if (nxt >= CHAIN_END) begin
              chain_done = 1'b1;
            end else begin
              cur_cluster = nxt;
              if (nxt < 2) begin
                chain_done = 1'b1;
                rep.bad = 1'b1;
              end
            end
          end
        end
      end
    endcase

    lba = '0;
    if (!chain_done) begin
      if (root_mode) lba = 32'(geo.root_lba) + 32'(root_index);
      else if (cur_cluster >= 2)
        lba = 32'(geo.data_lba) + (32'(cur_cluster) - 32'd2) * spc_eff()
              + 32'(sec_in_cluster);
    end
    rep.lba = lba[19:0];
    rep.eod = chain_done;
    rep.cl  = root_mode ? 12'd0 : cur_cluster;
    return rep;
  endfunction

  // Presents one item, waits for it to be taken and records its result.
  task automatic send_item(fcw_op_e op, logic [12:0] addr, logic [7:0] data,
                           logic [11:0] first);
    sector_report_t rep;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    opcode_i        <= op;
    fat_address_i   <= addr;
    fat_byte_i      <= data;
    first_cluster_i <= first;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    rep = step_walker(op, addr, data, first);
    expected_reports.push_back(rep);
    items_sent++;
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_for_reports();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Writes all five geometry registers while the walker is idle.
  task automatic write_geometry(int fat, int rlba, int rsecs, int dlba, int spc);
    fcw_cfg_t g;
    g.fat_size  = 14'(fat);
    g.root_lba  = 16'(rlba);
    g.root_secs = 13'(rsecs);
    g.data_lba  = 16'(dlba);
    g.spc       = 8'(spc);
    wait_for_reports();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_FAT_SIZE;
    cfg_data_i  <= 16'(g.fat_size);
    @(posedge clk_i);
    cfg_index_i <= CFG_ROOT_LBA;
    cfg_data_i  <= g.root_lba;
    @(posedge clk_i);
    cfg_index_i <= CFG_ROOT_SECS;
    cfg_data_i  <= 16'(g.root_secs);
    @(posedge clk_i);
    cfg_index_i <= CFG_DATA_LBA;
    cfg_data_i  <= g.data_lba;
    @(posedge clk_i);
    cfg_index_i <= CFG_SPC;
    cfg_data_i  <= 16'(g.spc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    geo = g;
  endtask

  // Loads the two bytes that hold a cluster's entry, keeping the neighbor's nibble.
  task automatic set_fat_entry(int unsigned cl, logic [11:0] val);
    int unsigned idx;
    logic [7:0] lo;
    logic [7:0] hi;
    idx = (cl * 3) / 2;
    lo = fat_known[idx] ? fat_mem[idx] : 8'($urandom);
    hi = fat_known[idx + 1] ? fat_mem[idx + 1] : 8'($urandom);
    if (cl % 2 == 0) begin
      lo = val[7:0];
      hi[3:0] = val[11:8];
    end else begin
      lo[7:4] = val[3:0];
      hi = val[11:4];
    end
    send_item(OP_LOAD, 13'(idx), lo, 12'($urandom));
    send_item(OP_LOAD, 13'(idx + 1), hi, 12'($urandom));
  endtask

  // Advances one sector; an entry the walker is about to read is loaded first.
  task automatic advance_sector();
    int unsigned idx;
    if (!chain_done && !root_mode && cur_cluster >= 2
        && int'(sec_in_cluster) + 1 >= spc_eff()) begin
      idx = (int'(cur_cluster) * 3) / 2;
      if (idx + 1 < fat_limit()) begin
        if (!fat_known[idx]) send_item(OP_LOAD, 13'(idx), 8'($urandom), 12'($urandom));
        if (!fat_known[idx + 1])
          send_item(OP_LOAD, 13'(idx + 1), 8'($urandom), 12'($urandom));
      end
    end
    send_item(OP_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom));
  endtask

  // Builds a short chain in the FAT, opens its head and walks it for up to 48 sectors.
  task automatic walk_random_chain();
    int unsigned links [6];
    int unsigned len;
    int unsigned top;
    int unsigned steps;
    logic [11:0] tail;
    top = (2 * fat_limit()) / 3 + 1;
    if (top > 'hFF7) top = 'hFF7;
    while (top >= 2 && (top * 3) / 2 + 1 >= fat_limit()) top--;
    if (top < 2) begin
      send_item(OP_OPEN, 13'($urandom), 8'($urandom), 12'($urandom_range(0, 8)));
      repeat (3) advance_sector();
      return;
    end
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) links[i] = $urandom_range(2, top);
    for (int i = 0; i + 1 < len; i++) set_fat_entry(links[i], 12'(links[i + 1]));

    // The chain ends in an end marker, a bad cluster, a cluster past the table,
    // or a random entry.
    case ($urandom_range(0, 3))
      0: tail = 12'($urandom_range(CHAIN_END, ENTRY_MASK));
      1: tail = 12'($urandom_range(0, 1));
      2: tail = (top < 'hFF7) ? 12'($urandom_range(top + 1, 'hFF7))
                              : 12'($urandom_range(2, top));
      default: tail = 12'($urandom);
    endcase
    set_fat_entry(links[len - 1], tail);

    send_item(OP_OPEN, 13'($urandom), 8'($urandom), 12'(links[0]));
    steps = len * spc_eff() + $urandom_range(0, 2);
    if (steps > 48) steps = $urandom_range(24, 48);
    repeat (steps) advance_sector();
    chains_walked++;
  endtask

  task automatic walk_root();
    int unsigned steps;
    send_item(OP_ROOT, 13'($urandom), 8'($urandom), 12'($urandom));
    steps = int'(geo.root_secs) + 2;
    steps = (steps > 40) ? $urandom_range(0, 40) : $urandom_range(0, steps);
    repeat (steps) advance_sector();
  endtask

  task automatic send_noise();
    fcw_op_e op;
    op = fcw_op_e'(2'($urandom_range(0, 3)));
    if (op == OP_ADVANCE) advance_sector();
    else send_item(op, 13'($urandom), 8'($urandom), 12'($urandom));
  endtask

  task automatic pick_geometry();
    int fat;
    int secs;
    int spc;
    case ($urandom_range(0, 4))
      0: fat = $urandom_range(0, 16);
      1: fat = $urandom_range(17, 600);
      2: fat = $urandom_range(601, 8191);
      3: fat = FAT_BYTES_DEF;
      default: fat = $urandom_range(8193, 16383);
    endcase
    case ($urandom_range(0, 3))
      0: secs = $urandom_range(0, 1);
      1, 2: secs = $urandom_range(2, 24);
      default: secs = $urandom_range(25, 8191);
    endcase
    case ($urandom_range(0, 7))
      0: spc = 0;
      1: spc = $urandom_range(129, 255);
      2: spc = $urandom_range(5, 128);
      default: spc = $urandom_range(1, 4);
    endcase
    write_geometry(fat, $urandom_range(0, 65535), secs, $urandom_range(0, 65535), spc);
  endtask

  // Right after reset the cursor is finished and the root is empty.
  task automatic test_after_reset();
    gap_pct = 25;
    advance_sector();
    send_item(OP_ROOT, 13'h0AAA, 8'h55, 12'h555);
    advance_sector();
  endtask

  // Every kind of open, a two-cluster chain over both entry parities,
  // a link into a bad cluster and the end of the root directory.
  task automatic test_open_and_chain();
    write_geometry(FAT_BYTES_DEF, 65535, 2, 65535, 2);
    send_item(OP_LOAD, 13'd0, 8'h00, 12'hFFF);
    send_item(OP_LOAD, 13'h1FFF, 8'hFF, 12'h000);
    send_item(OP_OPEN, '0, '0, 12'd0);
    send_item(OP_OPEN, '0, '0, 12'd1);
    send_item(OP_OPEN, '0, '0, CHAIN_END);
    send_item(OP_OPEN, '0, '0, ENTRY_MASK);
    set_fat_entry(2, 12'd3);
    set_fat_entry(3, ENTRY_MASK);
    send_item(OP_OPEN, '0, '0, 12'd2);
    repeat (5) advance_sector();
    set_fat_entry(4, 12'd1);
    send_item(OP_OPEN, '0, '0, 12'd4);
    repeat (3) advance_sector();
    send_item(OP_ROOT, '1, '1, '1);
    repeat (3) advance_sector();
  endtask

  // A chain that runs off a tiny FAT, zero and oversized cluster sizes,
  // an oversized FAT size and the highest usable cluster.
  task automatic test_limits();
    write_geometry(6, 16'h1234, 1, 0, 0);
    set_fat_entry(2, 12'd3);
    set_fat_entry(3, 12'd4);
    send_item(OP_OPEN, '0, '0, 12'd2);
    repeat (4) advance_sector();
    send_item(OP_ROOT, '0, '0, '0);
    advance_sector();

    write_geometry(16383, 0, 8191, 65535, 255);
    set_fat_entry('hFF7, CHAIN_END);
    send_item(OP_OPEN, '0, '0, 12'hFF7);
    repeat (130) advance_sector();
    send_item(OP_ROOT, '0, '0, '0);
    repeat (3) advance_sector();
  endtask

  // Phases of random geometry, mostly chain and root walks with noise
  // mixed in; the final phase runs without idling.
  task automatic test_random_walks();
    int phase_start;
    for (int phase = 0; phase < 8; phase++) begin
      pick_geometry();
      if (phase == 7) gap_pct = 0;
      else gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
      phase_start = items_sent;
      while (items_sent - phase_start < 180) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: walk_random_chain();
          6, 7: walk_root();
          default: repeat ($urandom_range(1, 4)) send_noise();
        endcase
      end
    end
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Each strobed result is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual sector 0x%0h",
                 $time, sector_lba_o);
        mismatches++;
      end else begin
        oldest_report = expected_reports.pop_front();
        check_field("sector_lba", oldest_report.lba, sector_lba_o);
        check_field("end_of_data", oldest_report.eod, end_of_data_o);
        check_field("bad_cluster", oldest_report.bad, bad_cluster_o);
        check_field("cluster_now", oldest_report.cl, cluster_now_o);
        reports_checked++;
      end
    end
  end

  // The run is stuck if neither an item nor a result moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_open_and_chain();
    test_limits();
    test_random_walks();

    wait_for_reports();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d items, walked %0d random cluster chains, checked %0d results.",
             items_sent, chains_walked, reports_checked);
    $display("Covered all opcodes, root walks, bad and past-table links, cluster sizes 0-255.");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
